### design/pnv_pkg.sv
// Shared types and fixed constants for the pink noise generator.
package pnv_pkg;

    localparam int ROWS    = 4;
    localparam int RAW_W   = 16;
    localparam int OUT_W   = 17;
    localparam int OUT_MIN = -65536;
    localparam int OUT_MAX = 65535;

    typedef logic [RAW_W-1:0]        raw_word_t;
    typedef logic signed [OUT_W-1:0] sample_t;

endpackage

### design/pnv_lane.sv
// One reduction lane: raw word modulo MODULUS via reciprocal multiply and one correction.
module pnv_lane #(
    parameter int MODULUS = 13107,
    parameter int VAL_W   = 14
) (
    input  logic              clk,
    input  logic              load,
    input  pnv_pkg::raw_word_t raw_word,
    output logic [VAL_W-1:0]  value
);

    localparam int RECIP   = (1 << pnv_pkg::RAW_W) / MODULUS;
    localparam int RECIP_W = (RECIP > 0) ? $clog2(RECIP + 1) : 1;
    localparam int PROD_W  = pnv_pkg::RAW_W + RECIP_W;
    localparam int MOD_W   = $clog2(MODULUS + 1);
    localparam int LW      = (MOD_W > pnv_pkg::RAW_W) ? MOD_W : pnv_pkg::RAW_W;

    pnv_pkg::raw_word_t word_reg;
    logic [RECIP_W-1:0] quot_reg;

    logic [PROD_W-1:0]  prod;
    logic [RECIP_W-1:0] quot_next;
    logic [LW-1:0]      qm;
    logic [LW-1:0]      diff;
    logic [LW-1:0]      rem;

    // quotient estimate is exact or one low
    assign prod      = PROD_W'(raw_word) * PROD_W'(RECIP);
    assign quot_next = prod[pnv_pkg::RAW_W +: RECIP_W];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= raw_word;
            quot_reg <= quot_next;
        end
    end

    always_comb
    begin
        qm   = LW'(quot_reg * MODULUS);
        diff = LW'(word_reg) - qm;
        if (diff >= LW'(MODULUS))
            rem = diff - LW'(MODULUS);
        else
            rem = diff;
    end

    assign value = VAL_W'(rem);

endmodule

### design/pink_noise_voss_generator.sv
// Pink noise generator top level: key counter, row store and output pipeline.
//
// Voss-McCartney pink noise, one sample out per request in. A request is taken in
// every cycle while the pipeline can move; a result appears once its request has passed
// the input register, reciprocal multiply, row update and output register, so while
// noise_stall is low the sustained rate is one sample per clock. A stage only stalls
// when the output register holds a result that is not taken and every stage between
// it and the output is full. Rows come out of reset at zero, so the first samples sit
// low until each row has been reloaded. The result is 2*S - RANGE in units of 1/RANGE.
module pink_noise_voss_generator #(
    parameter int KEY_LIMIT = 15,
    parameter int RANGE     = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sample_valid,
    output logic               sample_stall,
    input  pnv_pkg::raw_word_t extra_random,
    input  pnv_pkg::raw_word_t row_random_0,
    input  pnv_pkg::raw_word_t row_random_1,
    input  pnv_pkg::raw_word_t row_random_2,
    input  pnv_pkg::raw_word_t row_random_3,
    output logic               noise_valid,
    input  logic               noise_stall,
    output pnv_pkg::sample_t   noise_sample
);

    localparam int ROWS    = pnv_pkg::ROWS;
    localparam int MODULUS = RANGE / (ROWS + 1);
    localparam int MCLOG   = $clog2(MODULUS);
    localparam int VAL_W   = (MCLOG < pnv_pkg::RAW_W) ? MCLOG : pnv_pkg::RAW_W;
    localparam int SUM_W   = VAL_W + 3;
    localparam int RANGE_W = $clog2(RANGE + 1);
    localparam int CW_A    = (RANGE_W > SUM_W + 1) ? RANGE_W : SUM_W + 1;
    localparam int CW_B    = (CW_A > pnv_pkg::OUT_W) ? CW_A : pnv_pkg::OUT_W;
    localparam int CALC_W  = CW_B + 1;
    localparam int KEY_W   = $clog2(KEY_LIMIT + 1);
    localparam int MASK_W  = (KEY_W > ROWS) ? KEY_W : ROWS;

    localparam logic signed [CALC_W-1:0] SAT_LO = CALC_W'(pnv_pkg::OUT_MIN);
    localparam logic signed [CALC_W-1:0] SAT_HI = CALC_W'(pnv_pkg::OUT_MAX);

    // pipeline control
    logic v1_reg, v2_reg, v3_reg, out_v_reg;
    logic move1, move2, move3, accept;

    // key counter
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    logic [MASK_W-1:0] chg_ext;

    // stage payloads
    pnv_pkg::raw_word_t raw_reg [ROWS+1];
    logic [ROWS-1:0]    mask1_reg;
    logic [ROWS-1:0]    mask2_reg;
    logic [VAL_W-1:0]   lane_val [ROWS+1];
    logic [VAL_W-1:0]   rows_reg [ROWS];
    logic [VAL_W-1:0]   extra_reg;
    pnv_pkg::sample_t   out_reg;

    logic [SUM_W-1:0]         sum;
    logic signed [CALC_W-1:0] value;
    pnv_pkg::sample_t         sat_next;

    assign accept       = sample_valid && !sample_stall;
    assign move3        = v3_reg && (!out_v_reg || !noise_stall);
    assign move2        = v2_reg && (!v3_reg || move3);
    assign move1        = v1_reg && (!v2_reg || move2);
    assign sample_stall = v1_reg && !move1;

    assign key_next = (key_reg == KEY_W'(KEY_LIMIT)) ? '0 : key_reg + KEY_W'(1);
    assign chg_ext  = MASK_W'(key_reg ^ key_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
            key_reg   <= '0;
        end
        else
        begin
            if (accept)
                v1_reg <= 1'b1;
            else if (move1)
                v1_reg <= 1'b0;
            if (move1)
                v2_reg <= 1'b1;
            else if (move2)
                v2_reg <= 1'b0;
            if (move2)
                v3_reg <= 1'b1;
            else if (move3)
                v3_reg <= 1'b0;
            if (move3)
                out_v_reg <= 1'b1;
            else if (!noise_stall)
                out_v_reg <= 1'b0;
            if (accept)
                key_reg <= key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg[0] <= extra_random;
            raw_reg[1] <= row_random_0;
            raw_reg[2] <= row_random_1;
            raw_reg[3] <= row_random_2;
            raw_reg[4] <= row_random_3;
            mask1_reg  <= chg_ext[ROWS-1:0];
        end
        if (move1)
            mask2_reg <= mask1_reg;
        if (move2)
            extra_reg <= lane_val[0];
        if (move3)
            out_reg <= sat_next;
    end

    genvar g;
    generate
        for (g = 0; g < ROWS + 1; g++)
        begin : g_lane
            pnv_lane #(
                .MODULUS (MODULUS),
                .VAL_W   (VAL_W)
            ) u_lane (
                .clk      (clk),
                .load     (move1),
                .raw_word (raw_reg[g]),
                .value    (lane_val[g])
            );
        end
    endgenerate

    // rows only change as their request passes into the sum stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
                rows_reg[i] <= '0;
        end
        else if (move2)
        begin
            for (int i = 0; i < ROWS; i++)
                if (mask2_reg[i])
                    rows_reg[i] <= lane_val[i+1];
        end
    end

    always_comb
    begin
        sum = SUM_W'(extra_reg);
        for (int i = 0; i < ROWS; i++)
            sum = sum + SUM_W'(rows_reg[i]);
        value = $signed(CALC_W'({sum, 1'b0})) - $signed(CALC_W'(RANGE));
        if (value < SAT_LO)
            sat_next = SAT_LO[pnv_pkg::OUT_W-1:0];
        else if (value > SAT_HI)
            sat_next = SAT_HI[pnv_pkg::OUT_W-1:0];
        else
            sat_next = value[pnv_pkg::OUT_W-1:0];
    end

    assign noise_valid  = out_v_reg;
    assign noise_sample = out_reg;

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(key_reg) <= KEY_LIMIT)
        else $error("key counter past its limit");

    a_key_steps: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> key_reg != $past(key_reg))
        else $error("key did not step on an accepted request");

    a_key_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(key_reg))
        else $error("key moved without a request");

    a_rows_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !move2 |=> (rows_reg[0] == $past(rows_reg[0])) &&
                   (rows_reg[ROWS-1] == $past(rows_reg[ROWS-1])))
        else $error("row changed outside a row update");

    generate
        for (g = 0; g < ROWS; g++)
        begin : g_row_chk
            a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
                32'(rows_reg[g]) < MODULUS)
                else $error("row value not reduced");
        end
    endgenerate

endmodule

### bench/pink_noise_voss_generator_tb.sv
// Self-checking testbench for the Voss-McCartney pink noise generator.
module pink_noise_voss_generator_tb;

    localparam int ROWS       = pnv_pkg::ROWS;
    localparam int KEY_LIMIT  = 15;
    localparam int RANGE      = 65536;
    localparam int MODULUS    = RANGE / (ROWS + 1);
    localparam int RAND_TICKS = 1800;
    localparam int CYCLE_CAP  = 200000;
    localparam int DRAIN_WAIT = 20;

    typedef struct packed {
        pnv_pkg::raw_word_t               extra;
        pnv_pkg::raw_word_t [ROWS-1:0]    row;
    } tick_t;

    // Tracks the key counter and row store, predicts each noise sample.
    class pink_sample_predictor;
        int unsigned      key;
        int unsigned      row_held [ROWS];
        pnv_pkg::sample_t expected_samples [$];
        int               errors;
        int               checked;
        int               wraps;

        function new();
            key     = 0;
            errors  = 0;
            checked = 0;
            wraps   = 0;
            foreach (row_held[i]) row_held[i] = 0;
        endfunction

        function int unsigned fold(pnv_pkg::raw_word_t w);
            return int'(w) % MODULUS;
        endfunction

        function void note_request(tick_t t);
            int unsigned old_key;
            int unsigned flips;
            longint      sum;
            longint      v;
            old_key = key;
            if (key >= KEY_LIMIT)
            begin
                key = 0;
                wraps++;
            end
            else
                key = key + 1;
            flips = old_key ^ key;
            sum = fold(t.extra);
            for (int i = 0; i < ROWS; i++)
            begin
                if (flips[i])
                    row_held[i] = fold(t.row[i]);
                sum += row_held[i];
            end
            v = 2 * sum - RANGE;
            if (v < pnv_pkg::OUT_MIN)
                v = pnv_pkg::OUT_MIN;
            if (v > pnv_pkg::OUT_MAX)
                v = pnv_pkg::OUT_MAX;
            expected_samples.push_back(pnv_pkg::sample_t'(v));
        endfunction

        function void check_sample(pnv_pkg::sample_t actual);
            pnv_pkg::sample_t want;
            if (expected_samples.size() == 0)
            begin
                $display("%0t: noise sample %0d arrived with nothing expected",
                         $time, actual);
                errors++;
                return;
            end
            want = expected_samples.pop_front();
            checked++;
            if (actual !== want)
            begin
                $display("%0t: noise_sample mismatch, expected %0d, actual %0d",
                         $time, want, actual);
                errors++;
            end
        endfunction

        function int pending();
            return expected_samples.size();
        endfunction
    endclass

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    pnv_pkg::raw_word_t extra_random = '0;
    pnv_pkg::raw_word_t row_random_0 = '0;
    pnv_pkg::raw_word_t row_random_1 = '0;
    pnv_pkg::raw_word_t row_random_2 = '0;
    pnv_pkg::raw_word_t row_random_3 = '0;
    logic               noise_valid;
    logic               noise_stall  = 1'b0;
    pnv_pkg::sample_t   noise_sample;

    pink_sample_predictor predictor;
    int unsigned cycles = 0;
    int unsigned sent   = 0;

    pink_noise_voss_generator #(
        .KEY_LIMIT (KEY_LIMIT),
        .RANGE     (RANGE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .extra_random (extra_random),
        .row_random_0 (row_random_0),
        .row_random_1 (row_random_1),
        .row_random_2 (row_random_2),
        .row_random_3 (row_random_3),
        .noise_valid  (noise_valid),
        .noise_stall  (noise_stall),
        .noise_sample (noise_sample)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("%0t: run exceeded %0d cycles, %0d samples still expected",
                     $time, CYCLE_CAP, predictor.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall pattern: phases of no stall, light, heavy and mostly-stalled.
    int unsigned stall_mode  = 0;
    int unsigned stall_phase = 0;
    always @(posedge clk)
    begin
        if (stall_phase == 0)
        begin
            stall_mode  = $urandom_range(0, 3);
            stall_phase = $urandom_range(10, 80);
        end
        stall_phase = stall_phase - 1;
        case (stall_mode)
            0: noise_stall <= 1'b0;
            1: noise_stall <= ($urandom_range(0, 3) == 0);
            2: noise_stall <= ($urandom_range(0, 1) == 1);
            default: noise_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && noise_valid === 1'b1 && noise_stall === 1'b0)
            predictor.check_sample(noise_sample);
    end

    task automatic send_tick(tick_t t);
        sample_valid <= 1'b1;
        extra_random <= t.extra;
        row_random_0 <= t.row[0];
        row_random_1 <= t.row[1];
        row_random_2 <= t.row[2];
        row_random_3 <= t.row[3];
        do
            @(posedge clk);
        while (sample_stall !== 1'b0);
        predictor.note_request(t);
        sent++;
    endtask

    task automatic idle_for(int unsigned n);
        sample_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (predictor.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly full-range words, with a share sitting on the modulus boundaries.
    function automatic pnv_pkg::raw_word_t pick_raw();
        int k;
        int v;
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2, 3:
            begin
                k = $urandom_range(0, 5);
                v = k * MODULUS + $urandom_range(0, 4) - 2;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
                return pnv_pkg::raw_word_t'(v);
            end
            default: return pnv_pkg::raw_word_t'($urandom_range(0, 65535));
        endcase
    endfunction

    initial
    begin
        int unsigned corner [10];
        tick_t       t;
        int unsigned burst;
        predictor = new();
        corner = '{0, 65535, MODULUS - 1, MODULUS, MODULUS + 1, 65534,
                   2 * MODULUS, 4 * MODULUS - 1, 1, 5 * MODULUS - 1};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: corner words rotated over the fields, through one key wrap.
        for (int n = 0; n < 24; n++)
        begin
            t.extra = pnv_pkg::raw_word_t'(corner[n % 10]);
            for (int i = 0; i < ROWS; i++)
                t.row[i] = pnv_pkg::raw_word_t'(corner[(n + i + 1) % 10]);
            if (n == 0)
                t = '0;
            // the wrap tick reloads every row: all at modulus-1 gives the top value
            if (n == 15)
            begin
                t.extra = pnv_pkg::raw_word_t'(MODULUS - 1);
                for (int i = 0; i < ROWS; i++)
                    t.row[i] = pnv_pkg::raw_word_t'(MODULUS - 1);
            end
            send_tick(t);
        end
        wait_drained();

        burst = 0;
        for (int n = 0; n < RAND_TICKS; n++)
        begin
            if (n == RAND_TICKS / 2)
                wait_drained();
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                if ($urandom_range(0, 2) != 0)
                    idle_for($urandom_range(1, 8));
            end
            burst--;
            t.extra = pick_raw();
            for (int i = 0; i < ROWS; i++)
                t.row[i] = pick_raw();
            send_tick(t);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d sample requests across %0d key wraps; %0d noise samples checked.",
                 sent, predictor.wraps, predictor.checked);
        $display("Stimulus mixed corner words, modulus-edge words and full-range random.");
        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
